@@ rtl/core/tmq_pkg.sv @@
// package for the timed mailbox queue core
// holds action, status and flag codes and the slot record shared by the core modules
`timescale 1ns / 1ps

package tmq_pkg;

    localparam int unsigned SLOTS_DEFAULT = 16;
    localparam logic [31:0] TICK_TOP = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ACT_TICK = 3'd0,
        ACT_POST = 3'd1,
        ACT_GET  = 3'd2,
        ACT_GETC = 3'd3,
        ACT_STOP = 3'd4
    } action_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ERR   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] FLAG_DELAYED  = 2'd3;
    localparam logic [1:0] FLAG_FINISHED = 2'd2;
    localparam logic [1:0] FLAG_STOPPED  = 2'd0;

    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  mailbox;
        logic [7:0]  reply;
        logic [7:0]  command;
        logic [31:0] stamp;
        logic [15:0] delay;
        logic [7:0]  repeat_cnt;
    } slot_t;

endpackage

@@ rtl/core/tmq_slot_mem.sv @@
// slot memory of the timed mailbox queue: handles and payload, no list links
// one write port, one registered read port; depends on tmq_pkg
`timescale 1ns / 1ps

module tmq_slot_mem
    import tmq_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT,
    parameter int unsigned AW = $clog2(SLOTS)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  slot_t         wdata,
    input  logic [AW-1:0] raddr,
    output slot_t         rdata
);

    slot_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/timed_mailbox_queue_core.sv @@
// timed mailbox queue core: top level with the control sequencer
// uses tmq_pkg and tmq_slot_mem
`timescale 1ns / 1ps
//
// Command interface: a word is taken at a rising edge with start high and busy low.
// Exactly one result word follows per command, shown for one cycle with
// done high; the receiver cannot stall it, and busy stays high through that cycle.
// Tick, post and an undefined action pass through one execute state and one
// finish state before the result word, and the next command can be taken once
// busy falls after the result word. Post finds the lowest free slot from the
// occupancy bits combinationally.
// Get and stop walk the list from the head, one memory read per entry, with a
// read state and a check state per entry. A walk ends at the first hit, at the
// end of the list or after SLOTS entries, and then passes the finish state.
// Links and occupancy live in flip-flops per slot; handles and payload
// live in the slot memory, which stays undefined until written and needs no clear.
// Reset empties the list and clears the tick counter at once.
// List and counter state update in the execute or hit cycle, before the result.
//
module timed_mailbox_queue_core
    import tmq_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [2:0]  action,
    input  logic [15:0] tick_amount,
    input  logic [7:0]  mailbox_id,
    input  logic [7:0]  reply_id,
    input  logic [7:0]  command,
    input  logic [15:0] handle,
    input  logic [15:0] delay_ticks,
    input  logic [7:0]  repeat_count,
    output logic [1:0]  status,
    output logic [7:0]  command_out,
    output logic [15:0] handle_out,
    output logic [7:0]  reply_id_out,
    output logic        flag_write,
    output logic [1:0]  flag_value,
    output logic [31:0] tick_now
);

    localparam int unsigned AW = $clog2(SLOTS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_RD   = 5'b00100,
        S_CHK  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]  act_reg;
    logic [15:0] amt_reg, hdl_reg, dly_reg;
    logic [7:0]  mbx_reg, rep_reg, cmd_reg, rpt_reg;

    logic [31:0] tick_reg, tick_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [AW-1:0] nxt_reg [SLOTS];
    logic [AW-1:0] prv_reg [SLOTS];
    logic [SLOTS-1:0] hasn_reg, hasp_reg;
    logic [AW-1:0] head_reg, tail_reg;
    logic          empty_reg;

    logic [AW-1:0] cur_reg;
    logic          cur_ok_reg;
    logic [AW:0]   steps_reg;

    logic [1:0]  st_reg;
    logic [7:0]  co_reg, ro_reg;
    logic [15:0] ho_reg;
    logic        fw_reg;
    logic [1:0]  fv_reg;
    logic        done_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    slot_t         wdata, rdata;

    tmq_slot_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // free slot search
    logic [AW-1:0] free_idx;
    logic          free_ok;
    always_comb
    begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = AW'(i);
                free_ok  = 1'b1;
            end
        end
    end

    logic        accept;
    logic        match, ready_m;
    logic [31:0] diff;
    assign accept = start && !busy;
    assign raddr  = cur_reg;
    assign diff   = tick_reg - rdata.stamp;
    assign ready_m = (rdata.delay == 16'd0) || (diff > {16'd0, rdata.delay});
    always_comb
    begin
        if (act_reg == ACT_STOP)
        begin
            match = (rdata.handle == hdl_reg);
        end
        else
        begin
            match = (rdata.mailbox == mbx_reg) &&
                    ((act_reg == ACT_GET) || (rdata.command == cmd_reg)) && ready_m;
        end
    end

    // list bookkeeping, applied as unlink then optional append
    logic          do_unlink, do_append;
    logic [AW-1:0] ul_s, ap_s;
    logic [AW-1:0] nxt_next [SLOTS];
    logic [AW-1:0] prv_next [SLOTS];
    logic [SLOTS-1:0] hasn_next, hasp_next;
    logic [AW-1:0] head_next, tail_next, un, up;
    logic          empty_next, hn, hp;

    always_comb
    begin
        nxt_next   = nxt_reg;
        prv_next   = prv_reg;
        hasn_next  = hasn_reg;
        hasp_next  = hasp_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        un = nxt_reg[ul_s];
        up = prv_reg[ul_s];
        hn = hasn_reg[ul_s];
        hp = hasp_reg[ul_s];
        if (do_unlink)
        begin
            if (hn)
            begin
                prv_next[un]  = up;
                hasp_next[un] = hp;
            end
            if (hp)
            begin
                nxt_next[up]  = un;
                hasn_next[up] = hn;
            end
            if (!hp)
            begin
                head_next = un;
                if (!hn)
                begin
                    empty_next = 1'b1;
                end
            end
            if (!hn)
            begin
                tail_next = up;
            end
        end
        if (do_append)
        begin
            hasn_next[ap_s] = 1'b0;
            if (!empty_next)
            begin
                nxt_next[tail_next]  = ap_s;
                hasn_next[tail_next] = 1'b1;
                prv_next[ap_s]       = tail_next;
                hasp_next[ap_s]      = 1'b1;
            end
            else
            begin
                hasp_next[ap_s] = 1'b0;
                head_next       = ap_s;
            end
            tail_next  = ap_s;
            empty_next = 1'b0;
        end
    end

    logic [1:0]  st_n;
    logic [7:0]  co_n, ro_n;
    logic [15:0] ho_n;
    logic        fw_n;
    logic [1:0]  fv_n;
    logic [AW-1:0] cur_next;
    logic          cur_ok_next;
    logic [AW:0]   steps_next;

    always_comb
    begin
        state_next  = state_reg;
        tick_next   = tick_reg;
        used_next   = used_reg;
        do_unlink   = 1'b0;
        do_append   = 1'b0;
        ul_s        = cur_reg;
        ap_s        = cur_reg;
        we          = 1'b0;
        waddr       = cur_reg;
        wdata       = rdata;
        st_n = st_reg; co_n = co_reg; ro_n = ro_reg; ho_n = ho_reg;
        fw_n = fw_reg; fv_n = fv_reg;
        cur_next    = cur_reg;
        cur_ok_next = cur_ok_reg;
        steps_next  = steps_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                st_n = ST_ERR; co_n = '0; ro_n = '0; ho_n = '0;
                fw_n = 1'b0; fv_n = FLAG_STOPPED;
                state_next = S_DONE;
                unique case (act_reg) inside
                    ACT_TICK:
                    begin
                        st_n = ST_OK;
                        if ((TICK_TOP - tick_reg) <= {16'd0, amt_reg})
                        begin
                            tick_next = '0;
                        end
                        else
                        begin
                            tick_next = tick_reg + {16'd0, amt_reg};
                        end
                    end
                    ACT_POST:
                    begin
                        if (hdl_reg != 16'd0 && free_ok)
                        begin
                            st_n  = ST_OK;
                            we    = 1'b1;
                            waddr = free_idx;
                            wdata = '{handle: hdl_reg, mailbox: mbx_reg, reply: rep_reg,
                                      command: cmd_reg, stamp: tick_reg, delay: dly_reg,
                                      repeat_cnt: rpt_reg};
                            used_next[free_idx] = 1'b1;
                            do_append = 1'b1;
                            ap_s      = free_idx;
                            if (dly_reg != 16'd0)
                            begin
                                fw_n = 1'b1; fv_n = FLAG_DELAYED; ho_n = hdl_reg;
                            end
                        end
                    end
                    ACT_GET, ACT_GETC, ACT_STOP:
                    begin
                        st_n        = ST_EMPTY;
                        cur_next    = head_reg;
                        cur_ok_next = !empty_reg;
                        steps_next  = '0;
                        state_next  = S_RD;
                    end
                    default:
                    begin
                        st_n = ST_ERR;
                    end
                endcase
            end
            S_RD:
            begin
                if (!cur_ok_reg || steps_reg == (AW+1)'(SLOTS))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (match)
                begin
                    st_n       = ST_OK;
                    state_next = S_DONE;
                    do_unlink  = 1'b1;
                    if (act_reg == ACT_STOP)
                    begin
                        fw_n = 1'b1; fv_n = FLAG_STOPPED; ho_n = hdl_reg;
                        used_next[cur_reg] = 1'b0;
                    end
                    else
                    begin
                        co_n = rdata.command; ho_n = rdata.handle; ro_n = rdata.reply;
                        if (rdata.delay != 16'd0 && rdata.repeat_cnt > 8'd1)
                        begin
                            do_append = 1'b1;
                            we = 1'b1;
                            wdata.repeat_cnt = rdata.repeat_cnt - 8'd1;
                            wdata.stamp      = tick_reg;
                        end
                        else
                        begin
                            used_next[cur_reg] = 1'b0;
                            if (rdata.delay != 16'd0)
                            begin
                                fw_n = 1'b1; fv_n = FLAG_FINISHED;
                            end
                        end
                    end
                    if (!do_append)
                    begin
                        // freed slot: handle cleared so stop cannot hit it later
                        we = 1'b1;
                        wdata.handle = '0;
                    end
                end
                else
                begin
                    cur_next    = nxt_reg[cur_reg];
                    cur_ok_next = hasn_reg[cur_reg];
                    steps_next  = steps_reg + 1'b1;
                    state_next  = S_RD;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tick_reg  <= '0;
            used_reg  <= '0;
            hasn_reg  <= '0;
            hasp_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            done_reg  <= 1'b0;
            cur_ok_reg <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            used_reg   <= used_next;
            hasn_reg   <= hasn_next;
            hasp_reg   <= hasp_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            empty_reg  <= empty_next;
            done_reg   <= (state_reg == S_DONE);
            cur_ok_reg <= cur_ok_next;
            steps_reg  <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nxt_reg <= nxt_next;
        prv_reg <= prv_next;
        cur_reg <= cur_next;
        st_reg <= st_n; co_reg <= co_n; ro_reg <= ro_n; ho_reg <= ho_n;
        fw_reg <= fw_n; fv_reg <= fv_n;
        if (accept)
        begin
            act_reg <= action;
            amt_reg <= tick_amount;
            mbx_reg <= mailbox_id;
            rep_reg <= reply_id;
            cmd_reg <= command;
            hdl_reg <= handle;
            dly_reg <= delay_ticks;
            rpt_reg <= repeat_count;
        end
    end

    assign busy         = (state_reg != S_IDLE) || done_reg;
    assign done         = done_reg;
    assign status       = st_reg;
    assign command_out  = co_reg;
    assign handle_out   = ho_reg;
    assign reply_id_out = ro_reg;
    assign flag_write   = fw_reg;
    assign flag_value   = fv_reg;
    assign tick_now     = tick_reg;

    a_done_after_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> done)
        else $error("result word missing");
    a_empty_no_used: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (used_reg == '0))
        else $error("empty list with occupied slots");
    a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("busy low during result");
    a_flag_has_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && flag_write) |-> (handle_out != 16'd0))
        else $error("flag write without handle");

endmodule

@@ dv/tb_timed_mailbox_queue_core.sv @@
// testbench for timed_mailbox_queue_core: directed and random command words
// checked against an in-bench model of the slot list and tick counter
`timescale 1ns / 1ps

module tb_timed_mailbox_queue_core
    import tmq_pkg::*;
();

    localparam int NSLOT = SLOTS_DEFAULT;
    localparam logic [4:0] NIL = 5'(NSLOT);

    typedef struct {
        logic [1:0]  st;
        logic [7:0]  cmd;
        logic [15:0] hnd;
        logic [7:0]  rpl;
        logic        fw;
        logic [1:0]  fv;
        logic [31:0] tk;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy, done;
    logic [2:0]  action = '0;
    logic [15:0] tick_amount = '0;
    logic [7:0]  mailbox_id = '0;
    logic [7:0]  reply_id = '0;
    logic [7:0]  command = '0;
    logic [15:0] handle = '0;
    logic [15:0] delay_ticks = '0;
    logic [7:0]  repeat_count = '0;
    logic [1:0]  status;
    logic [7:0]  command_out;
    logic [15:0] handle_out;
    logic [7:0]  reply_id_out;
    logic        flag_write;
    logic [1:0]  flag_value;
    logic [31:0] tick_now;

    word_t pending_words[$];
    int    n_errors = 0;
    bit    burst_mode = 1'b0;

    // model state
    logic [31:0] mdl_ticks;
    logic [15:0] mdl_hnd[NSLOT];
    logic [7:0]  mdl_mbx[NSLOT];
    logic [7:0]  mdl_rpl[NSLOT];
    logic [7:0]  mdl_cmd[NSLOT];
    logic [31:0] mdl_stamp[NSLOT];
    logic [15:0] mdl_dly[NSLOT];
    logic [7:0]  mdl_rpt[NSLOT];
    logic [4:0]  mdl_next[NSLOT];
    logic [4:0]  mdl_prev[NSLOT];
    logic [4:0]  mdl_head, mdl_tail;

    timed_mailbox_queue_core u_top (.*);

    always #1 clk = ~clk;

    initial
    begin
        #5000000;
        $display("FAIL timed_mailbox_queue_core");
        $finish;
    end

    function automatic void list_unlink(logic [4:0] s);
        logic [4:0] n, p;
        n = mdl_next[s];
        p = mdl_prev[s];
        if (n != NIL) mdl_prev[n] = p;
        if (p != NIL) mdl_next[p] = n;
        if (mdl_head == s) mdl_head = n;
        if (mdl_tail == s) mdl_tail = p;
    endfunction

    function automatic void list_append(logic [4:0] s);
        mdl_next[s] = NIL;
        if (mdl_tail != NIL)
        begin
            mdl_next[mdl_tail] = s;
            mdl_prev[s] = mdl_tail;
        end
        else
        begin
            mdl_prev[s] = NIL;
            mdl_head = s;
        end
        mdl_tail = s;
    endfunction

    function automatic void slot_release(logic [4:0] s);
        mdl_hnd[s] = '0;
        mdl_dly[s] = '0;
        mdl_rpt[s] = '0;
    endfunction

    function automatic void mailbox_reset();
        mdl_ticks = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            mdl_hnd[i] = '0;
            mdl_stamp[i] = '0;
            mdl_dly[i] = '0;
            mdl_rpt[i] = '0;
            mdl_next[i] = NIL;
            mdl_prev[i] = NIL;
        end
        mdl_head = NIL;
        mdl_tail = NIL;
    endfunction

    function automatic word_t mailbox_step(logic [2:0] act, logic [15:0] amt, logic [7:0] mbx,
                                           logic [7:0] rpl, logic [7:0] cmd, logic [15:0] hnd,
                                           logic [15:0] dly, logic [7:0] rpt);
        word_t w;
        logic [4:0] s, nxt;
        int free_s;
        w = '{ST_ERR, 8'd0, 16'd0, 8'd0, 1'b0, FLAG_STOPPED, 32'd0};
        if (act == ACT_TICK)
        begin
            if ((TICK_TOP - mdl_ticks) <= {16'd0, amt}) mdl_ticks = '0;
            else mdl_ticks = mdl_ticks + {16'd0, amt};
            w.st = ST_OK;
        end
        else if (act == ACT_POST)
        begin
            free_s = -1;
            for (int i = 0; i < NSLOT; i++)
                if (free_s < 0 && mdl_hnd[i] == 0) free_s = i;
            if (hnd != 0 && free_s >= 0)
            begin
                s = 5'(free_s);
                mdl_hnd[s] = hnd;
                mdl_mbx[s] = mbx;
                mdl_rpl[s] = rpl;
                mdl_cmd[s] = cmd;
                mdl_stamp[s] = mdl_ticks;
                mdl_dly[s] = dly;
                mdl_rpt[s] = rpt;
                if (dly != 0)
                begin
                    w.fw = 1'b1;
                    w.fv = FLAG_DELAYED;
                    w.hnd = hnd;
                end
                list_append(s);
                w.st = ST_OK;
            end
        end
        else if (act == ACT_GET || act == ACT_GETC)
        begin
            w.st = ST_EMPTY;
            s = mdl_head;
            for (int k = 0; k < NSLOT && s != NIL; k++)
            begin
                nxt = mdl_next[s];
                if (mdl_mbx[s] == mbx && (act == ACT_GET || mdl_cmd[s] == cmd) &&
                    (mdl_dly[s] == 0 || (mdl_ticks - mdl_stamp[s]) > {16'd0, mdl_dly[s]}))
                begin
                    w.st = ST_OK;
                    w.cmd = mdl_cmd[s];
                    w.hnd = mdl_hnd[s];
                    w.rpl = mdl_rpl[s];
                    list_unlink(s);
                    if (mdl_dly[s] == 0)
                        slot_release(s);
                    else if (mdl_rpt[s] <= 1)
                    begin
                        w.fw = 1'b1;
                        w.fv = FLAG_FINISHED;
                        slot_release(s);
                    end
                    else
                    begin
                        list_append(s);
                        mdl_rpt[s] = mdl_rpt[s] - 8'd1;
                        mdl_stamp[s] = mdl_ticks;
                    end
                    break;
                end
                s = nxt;
            end
        end
        else if (act == ACT_STOP)
        begin
            w.st = ST_EMPTY;
            s = mdl_head;
            for (int k = 0; k < NSLOT && s != NIL; k++)
            begin
                if (mdl_hnd[s] == hnd)
                begin
                    w.st = ST_OK;
                    w.fw = 1'b1;
                    w.fv = FLAG_STOPPED;
                    w.hnd = hnd;
                    list_unlink(s);
                    slot_release(s);
                    break;
                end
                s = mdl_next[s];
            end
        end
        w.tk = mdl_ticks;
        return w;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        word_t e;
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result word, expected none, actual status %0h",
                         $time, status);
            end
            else
            begin
                e = pending_words.pop_front();
                check_field("status", 32'(e.st), 32'(status));
                check_field("command_out", 32'(e.cmd), 32'(command_out));
                check_field("handle_out", 32'(e.hnd), 32'(handle_out));
                check_field("reply_id_out", 32'(e.rpl), 32'(reply_id_out));
                check_field("flag_write", 32'(e.fw), 32'(flag_write));
                check_field("flag_value", 32'(e.fv), 32'(flag_value));
                check_field("tick_now", e.tk, tick_now);
            end
        end
    end

    // called at a rising edge; leaves start high after the word is taken
    task automatic send_word(logic [2:0] act, logic [15:0] amt, logic [7:0] mbx,
                             logic [7:0] rpl, logic [7:0] cmd, logic [15:0] hnd,
                             logic [15:0] dly, logic [7:0] rpt);
        start <= 1'b1;
        action <= act;
        tick_amount <= amt;
        mailbox_id <= mbx;
        reply_id <= rpl;
        command <= cmd;
        handle <= hnd;
        delay_ticks <= dly;
        repeat_count <= rpt;
        do @(posedge clk); while (busy);
        pending_words.push_back(mailbox_step(act, amt, mbx, rpl, cmd, hnd, dly, rpt));
    endtask

    task automatic idle_gap();
        int r, n;
        r = $urandom_range(0, 99);
        n = 0;
        if (!burst_mode)
        begin
            if (r >= 90) n = $urandom_range(10, 40);
            else if (r >= 45) n = $urandom_range(1, 3);
        end
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_basic_post_get();
        send_word(ACT_TICK, 16'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        send_word(ACT_POST, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 16'd5, 8'd2);
        send_word(ACT_POST, 16'd0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'd0, 8'hFF);
        send_word(ACT_POST, 16'd0, 8'h00, 8'h00, 8'h00, 16'h0001, 16'd0, 8'd0);
        send_word(ACT_GET, 16'd0, 8'h12, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        send_word(ACT_GETC, 16'd0, 8'hFF, 8'd0, 8'h00, 16'd0, 16'd0, 8'd0);
        send_word(ACT_GETC, 16'd0, 8'hFF, 8'd0, 8'hFF, 16'd0, 16'd0, 8'd0);
        send_word(ACT_GET, 16'd0, 8'h00, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        idle_gap();
    endtask

    task automatic test_delay_repeat();
        send_word(ACT_POST, 16'd0, 8'd7, 8'd9, 8'd3, 16'h0A0A, 16'd4, 8'd3);
        send_word(ACT_POST, 16'd0, 8'd7, 8'd8, 8'd4, 16'h0B0B, 16'hFFFF, 8'd0);
        send_word(ACT_GET, 16'd0, 8'd7, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        send_word(ACT_TICK, 16'd4, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        send_word(ACT_GET, 16'd0, 8'd7, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        send_word(ACT_TICK, 16'd1, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        for (int i = 0; i < 3; i++)
        begin
            send_word(ACT_GETC, 16'd0, 8'd7, 8'd0, 8'd3, 16'd0, 16'd0, 8'd0);
            send_word(ACT_TICK, 16'd5, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        end
        send_word(ACT_TICK, 16'hFFFF, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        send_word(ACT_GET, 16'd0, 8'd7, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        drain();
    endtask

    task automatic test_stop();
        send_word(ACT_POST, 16'd0, 8'd1, 8'd1, 8'd1, 16'h0C0C, 16'd2, 8'd2);
        send_word(ACT_STOP, 16'd0, 8'd0, 8'd0, 8'd0, 16'h0D0D, 16'd0, 8'd0);
        send_word(ACT_STOP, 16'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        send_word(ACT_STOP, 16'd0, 8'd0, 8'd0, 8'd0, 16'h0C0C, 16'd0, 8'd0);
        send_word(ACT_STOP, 16'd0, 8'd0, 8'd0, 8'd0, 16'h0C0C, 16'd0, 8'd0);
        idle_gap();
    endtask

    task automatic test_pool_full();
        for (int i = 0; i <= NSLOT; i++)
            send_word(ACT_POST, 16'd0, 8'd2, 8'(i), 8'(i), 16'(i + 1), 16'd0, 8'd0);
        send_word(ACT_POST, 16'd0, 8'd2, 8'd0, 8'd0, 16'd1, 16'd0, 8'd0);
        send_word(ACT_STOP, 16'd0, 8'd0, 8'd0, 8'd0, 16'd16, 16'd0, 8'd0);
        for (int i = 0; i < NSLOT; i++)
            send_word(ACT_GET, 16'd0, 8'd2, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        drain();
    endtask

    task automatic test_bad_action();
        for (int a = 5; a < 8; a++)
            send_word(3'(a), 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        idle_gap();
    endtask

    task automatic test_tick_large();
        burst_mode = 1'b1;
        for (int i = 0; i < 40; i++)
            send_word(ACT_TICK, 16'hFFFF, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        drain();
    endtask

    task automatic test_random();
        int r;
        logic [2:0] act;
        logic [15:0] amt, hnd, dly;
        logic [7:0] mbx, cmd, rpt;
        for (int i = 0; i < 1300; i++)
        begin
            if (i % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 15) act = ACT_TICK;
            else if (r < 45) act = ACT_POST;
            else if (r < 70) act = ACT_GET;
            else if (r < 85) act = ACT_GETC;
            else if (r < 95) act = ACT_STOP;
            else act = 3'($urandom_range(5, 7));
            amt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
            mbx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            hnd = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10));
            r = $urandom_range(0, 9);
            dly = (r < 4) ? 16'd0 : (r < 9) ? 16'($urandom_range(1, 8)) : 16'($urandom);
            rpt = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            send_word(act, amt, mbx, 8'($urandom), cmd, hnd, dly, rpt);
            if (i == 650) drain();
            else idle_gap();
        end
    endtask

    initial
    begin
        mailbox_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_post_get();
        test_delay_repeat();
        test_stop();
        test_pool_full();
        test_bad_action();
        test_tick_large();
        test_random();
        drain();
        repeat (50) @(posedge clk);
        if (n_errors == 0)
            $display("PASS timed_mailbox_queue_core");
        else
            $display("FAIL timed_mailbox_queue_core");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/tmq_pkg.sv
rtl/core/tmq_slot_mem.sv
rtl/core/timed_mailbox_queue_core.sv
dv/tb_timed_mailbox_queue_core.sv
